@@ sv/stb_pkg.sv @@
package stb_pkg;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_START   = 2'd2,
    OP_DESTROY = 2'd3
  } op_t;

  // Result codes on the output channel
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_ALLOC_OK   = 3'd1,
    EV_ALLOC_FAIL = 3'd2,
    EV_FIRED      = 3'd3,
    EV_WATCHDOG   = 3'd4
  } event_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_TICK_PERIOD = 1'b0,
    REG_WD_INTERVAL = 1'b1
  } cfg_reg_t;

  localparam int TICK_W   = 10;
  localparam int WDI_W    = 16;
  localparam int MS_W     = 11;
  localparam int WDC_W    = 17;
  localparam int SEC_W    = 32;
  localparam int SLOT_W   = 3;
  localparam int CFG_IW   = 1;

  localparam logic [MS_W-1:0]   MS_PER_SECOND     = 11'd1000;
  localparam logic [TICK_W-1:0] RESET_TICK_PERIOD = 10'd10;
  localparam logic [WDI_W-1:0]  RESET_WD_INTERVAL = 16'd2000;

  // Configuration seen by the back end
  typedef struct packed {
    logic [TICK_W-1:0] tick_period;
    logic [WDI_W-1:0]  wd_interval;
  } cfg_t;

  // Classified request held in the front queue
  typedef struct packed {
    op_t              op;
    logic [SLOT_W-1:0] slot;
    logic             slot_ok;
    logic [SEC_W-1:0] period;
    logic             one_shot;
  } cmd_t;

endpackage

@@ sv/software_timer_bank_unit.sv @@
// Channel  | Direction | Handshake        | Payload
// ---------+-----------+------------------+---------------------------------------------
// in_      | input     | in_valid/stall   | kind, slot, period_seconds, one_shot
// out_     | output    | out_valid/stall  | event_res, event_slot, last
// cfg_     | input     | cfg_valid/ready  | index (0 tick period, 1 watchdog), data
//
// A request enters a two-entry queue, and the back end takes it from there when idle.
// A tick that rolls over a second runs a scan that reads one slot per cycle from the
// period/start memories unless output stall holds it; allocate walks the slots for the
// lowest free one, while other ticks, start and destroy need no scan.
// Synchronous active-low reset clears all slots and counters; no clearing pass is needed.
// Output stall holds the scan only when a slot fires while a result is pending.
module software_timer_bank_unit import stb_pkg::*; #(
  parameter int NUM_TIMERS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [SEC_W-1:0]  in_period_seconds,
  input  logic              in_one_shot,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_event_res,
  output logic [SLOT_W-1:0] out_event_slot,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [WDI_W-1:0]  cfg_data
);

  cfg_t cfg_r;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_period <= RESET_TICK_PERIOD;
      cfg_r.wd_interval <= RESET_WD_INTERVAL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TICK_PERIOD: cfg_r.tick_period <= cfg_data[TICK_W-1:0];
        REG_WD_INTERVAL: cfg_r.wd_interval <= cfg_data;
      endcase
    end
  end

  stb_front #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_slot           (in_slot),
    .in_period_seconds (in_period_seconds),
    .in_one_shot       (in_one_shot),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop)
  );

  stb_back #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_res  (out_event_res),
    .out_event_slot (out_event_slot),
    .out_last       (out_last)
  );

endmodule

@@ sv/stb_front.sv @@
module stb_front import stb_pkg::*; #(
  parameter int NUM_TIMERS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [SEC_W-1:0]  in_period_seconds,
  input  logic              in_one_shot,
  output logic              q_valid,
  output cmd_t              q_cmd,
  input  logic              q_pop
);

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  cmd_t       cmd_in;

  // Classify the request
  always_comb begin
    cmd_in.op       = op_t'(in_kind);
    cmd_in.slot     = in_slot;
    cmd_in.slot_ok  = (32'(in_slot) < NUM_TIMERS);
    cmd_in.period   = in_period_seconds;
    cmd_in.one_shot = in_one_shot;
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  // Two-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        q_mem_r[wr_ptr_r] <= cmd_in;
        wr_ptr_r          <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

@@ sv/stb_back.sv @@
module stb_back import stb_pkg::*; #(
  parameter int NUM_TIMERS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_event_res,
  output logic [SLOT_W-1:0] out_event_slot,
  output logic              out_last
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC,
    ST_WDOG,
    ST_FINISH
  } state_t;

  state_t              state_r;
  logic [MS_W-1:0]     millis_r;
  logic [SEC_W-1:0]    seconds_r;
  logic [WDC_W-1:0]    wd_count_r;
  logic                wd_fire_r;
  logic [NUM_TIMERS-1:0] alloc_r;
  logic [NUM_TIMERS-1:0] en_r;
  logic [NUM_TIMERS-1:0] os_r;

  // Per-slot period and start time, valid only while the slot is enabled
  logic [SEC_W-1:0]    period_mem [NUM_TIMERS];
  logic [SEC_W-1:0]    start_mem  [NUM_TIMERS];
  logic [SEC_W-1:0]    period_q_r;
  logic [SEC_W-1:0]    start_q_r;

  // Scan pipeline: read stage and compare stage
  logic [IDX_W-1:0]    rd_idx_r;
  logic                rd_live_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic                cmp_valid_r;

  // One result held back so that the final one can carry last
  logic                pend_valid_r;
  event_t              pend_res_r;
  logic [SLOT_W-1:0]   pend_slot_r;

  logic                out_valid_r;
  event_t              out_res_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_last_r;

  logic                out_free;
  logic                out_load;
  logic                fire;
  logic                advance;
  logic                mem_rd_en;
  logic [IDX_W-1:0]    sidx;
  logic                start_ok;
  logic                pd_we;
  logic                st_we;
  logic [IDX_W-1:0]    st_waddr;
  logic [MS_W-1:0]     ms_sum;
  logic [WDC_W-1:0]    wd_sum;

  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = cmp_valid_r && en_r[cmp_idx_r] &&
                     ((seconds_r - start_q_r) > period_q_r);
  assign advance   = !(fire && pend_valid_r && !out_free);
  assign mem_rd_en = (state_r == ST_SCAN) && advance && rd_live_r;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign sidx      = IDX_W'(q_cmd.slot);
  assign start_ok  = q_cmd.slot_ok && alloc_r[sidx];
  assign ms_sum    = millis_r + MS_W'(cfg.tick_period);
  assign wd_sum    = wd_count_r + WDC_W'(cfg.tick_period);

  // Output register loads a new result this cycle
  assign out_load  = ((state_r == ST_SCAN) && advance && fire && pend_valid_r) ||
                     ((state_r == ST_WDOG) && wd_fire_r && pend_valid_r && out_free) ||
                     ((state_r == ST_FINISH) && out_free);

  // Memory write selection: start request or a firing slot
  assign pd_we    = q_pop && (q_cmd.op == OP_START) && start_ok;
  assign st_we    = pd_we || ((state_r == ST_SCAN) && advance && fire);
  assign st_waddr = pd_we ? sidx : cmp_idx_r;

  always_ff @(posedge clk) begin
    if (pd_we) begin
      period_mem[sidx] <= q_cmd.period;
    end
    if (mem_rd_en) begin
      period_q_r <= period_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      start_mem[st_waddr] <= seconds_r;
    end
    if (mem_rd_en) begin
      start_q_r <= start_mem[rd_idx_r];
    end
  end

  // Sequencer, timer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      millis_r     <= '0;
      seconds_r    <= '0;
      wd_count_r   <= '0;
      wd_fire_r    <= 1'b0;
      alloc_r      <= '0;
      en_r         <= '0;
      os_r         <= '0;
      rd_live_r    <= 1'b0;
      cmp_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            unique case (q_cmd.op)
              OP_TICK: begin
                if (wd_sum > WDC_W'(cfg.wd_interval)) begin
                  wd_count_r <= '0;
                  wd_fire_r  <= 1'b1;
                end else begin
                  wd_count_r <= wd_sum;
                  wd_fire_r  <= 1'b0;
                end
                if (ms_sum >= MS_PER_SECOND) begin
                  millis_r    <= '0;
                  seconds_r   <= seconds_r + SEC_W'(1);
                  rd_idx_r    <= '0;
                  rd_live_r   <= 1'b1;
                  cmp_valid_r <= 1'b0;
                  state_r     <= ST_SCAN;
                end else begin
                  millis_r <= ms_sum;
                  state_r  <= ST_WDOG;
                end
              end
              OP_ALLOC: begin
                rd_idx_r <= '0;
                state_r  <= ST_ALLOC;
              end
              OP_START: begin
                if (start_ok) begin
                  en_r[sidx] <= 1'b1;
                  os_r[sidx] <= q_cmd.one_shot;
                end
                state_r <= ST_FINISH;
              end
              OP_DESTROY: begin
                if (q_cmd.slot_ok) begin
                  alloc_r[sidx] <= 1'b0;
                  en_r[sidx]    <= 1'b0;
                  os_r[sidx]    <= 1'b0;
                end
                state_r <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (advance) begin
            if (fire) begin
              if (pend_valid_r) begin
                out_valid_r <= 1'b1;
                out_res_r   <= pend_res_r;
                out_slot_r  <= pend_slot_r;
                out_last_r  <= 1'b0;
              end
              pend_valid_r <= 1'b1;
              pend_res_r   <= EV_FIRED;
              pend_slot_r  <= SLOT_W'(cmp_idx_r);
              if (os_r[cmp_idx_r]) begin
                en_r[cmp_idx_r] <= 1'b0;
              end
            end
            cmp_valid_r <= rd_live_r;
            cmp_idx_r   <= rd_idx_r;
            if (rd_live_r && (rd_idx_r != LAST_IDX)) begin
              rd_idx_r <= rd_idx_r + IDX_W'(1);
            end else begin
              rd_live_r <= 1'b0;
            end
            if (!rd_live_r) begin
              state_r <= ST_WDOG;
            end
          end
        end
        ST_ALLOC: begin
          // Walk the slots for the lowest free one
          if (!alloc_r[rd_idx_r]) begin
            alloc_r[rd_idx_r] <= 1'b1;
            pend_valid_r      <= 1'b1;
            pend_res_r        <= EV_ALLOC_OK;
            pend_slot_r       <= SLOT_W'(rd_idx_r);
            state_r           <= ST_FINISH;
          end else if (rd_idx_r == LAST_IDX) begin
            pend_valid_r <= 1'b1;
            pend_res_r   <= EV_ALLOC_FAIL;
            pend_slot_r  <= '0;
            state_r      <= ST_FINISH;
          end else begin
            rd_idx_r <= rd_idx_r + IDX_W'(1);
          end
        end
        ST_WDOG: begin
          if (!wd_fire_r) begin
            state_r <= ST_FINISH;
          end else if (!pend_valid_r || out_free) begin
            if (pend_valid_r) begin
              out_valid_r <= 1'b1;
              out_res_r   <= pend_res_r;
              out_slot_r  <= pend_slot_r;
              out_last_r  <= 1'b0;
            end
            pend_valid_r <= 1'b1;
            pend_res_r   <= EV_WATCHDOG;
            pend_slot_r  <= '0;
            state_r      <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_res_r    <= pend_valid_r ? pend_res_r : EV_NONE;
            out_slot_r   <= pend_valid_r ? pend_slot_r : '0;
            out_last_r   <= 1'b1;
            pend_valid_r <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = out_res_r;
  assign out_event_slot = out_slot_r;
  assign out_last       = out_last_r;

endmodule

@@ sv/stb_checker.sv @@
module stb_checker import stb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        out_event_res,
  input logic [SLOT_W-1:0] out_event_slot,
  input logic              out_last
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_event_res) && $stable(out_event_slot) &&
                               $stable(out_last))
    else $error("result changed while stalled");

  // Only allocation successes and fire results carry a slot
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_NONE || out_event_res == EV_ALLOC_FAIL ||
                  out_event_res == EV_WATCHDOG) |-> out_event_slot == '0)
    else $error("slot set on a slotless result");

  // Allocation and empty results are always single, so always last
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_NONE || out_event_res == EV_ALLOC_OK ||
                  out_event_res == EV_ALLOC_FAIL) |-> out_last)
    else $error("single result without last");

  // Watchdog feed closes a tick's results
  a_wd_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_WATCHDOG |-> out_last)
    else $error("watchdog feed not last");

endmodule

bind software_timer_bank_unit stb_checker u_stb_checker (.*);
